// ===== src/lppd_pkg.sv =====
// Shared types and constants of the length-prefixed packet deframer.
package lppd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned LEN_W  = 15;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRANSFER    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_READER_CAPACITY = 1'b1;

  localparam logic [LEN_W-1:0] MAX_TRANSFER_RST    = 15'd1024;
  localparam logic [LEN_W-1:0] READER_CAPACITY_RST = 15'd1024;

  // Shortest accepted packet length, the two header bytes included.
  localparam logic [LEN_W-1:0] MIN_LEN = 15'd4;

  // Default depth of the result queue.
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic [TIME_W-1:0] arrival_time_us;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_packet;
    logic [TIME_W-1:0] packet_time_us;
    logic [LEN_W-1:0]  packet_length;
  } out_item_t;

  // Results produced by one input byte: none, one or two.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

endpackage

// ===== src/lppd_stream_if.sv =====
// Valid/ready stream interface carrying one payload per transaction.
interface lppd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/length_prefixed_packet_deframer.sv =====
// Top level of the length-prefixed packet deframer.
//
//   Port    Direction  Transaction carries
//   in_ch   sink       rx_byte, arrival_time_us
//   out_ch  source     out_byte, last_of_packet, packet_time_us, packet_length
//   cfg_*   sink       write of max_transfer (index 0) or reader_capacity (index 1)
//
// A byte is taken in any cycle in which the input register is empty or its byte
// moves on, which needs two free queue slots; it is decoded as it moves on, and
// its results are written into the queue, from whose head out_ch is fed.
// The second header byte of a passed-on packet yields two results, every later byte one.
// Reset is synchronous and active low; it restores both registers to 1024 and empties
// the queue. A stall on out_ch fills the queue, and then in_ch stalls as well.
module length_prefixed_packet_deframer #(
  parameter int unsigned QueueDepth = lppd_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  lppd_stream_if.sink                    in_ch,
  lppd_stream_if.source                  out_ch,
  input  logic                           cfg_we,
  input  logic [lppd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lppd_pkg::LEN_W-1:0]     cfg_wdata
);
  import lppd_pkg::*;

  // Group of results handed from the decoder to the queue each cycle.
  push_t     push;
  // The queue can take the two results that a header byte may produce.
  logic      space_ok;
  logic      in_ready;
  out_item_t out_item;
  logic      out_valid;

  lppd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_item  (in_ch.payload),
    .in_ready (in_ready),
    .space_ok (space_ok),
    .push     (push),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  lppd_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_valid(out_valid),
    .out_ready(out_ch.ready),
    .out_item (out_item)
  );

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

endmodule

// ===== src/lppd_core.sv =====
// Input register, configuration registers and the header/packet state machine.
module lppd_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  lppd_pkg::in_item_t                  in_item,
  output logic                                in_ready,
  input  logic                                space_ok,
  output lppd_pkg::push_t                     push,
  input  logic                                cfg_we,
  input  logic [lppd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lppd_pkg::LEN_W-1:0]          cfg_wdata
);
  import lppd_pkg::*;

  localparam logic [1:0] PH_LOW  = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_PASS = 2'd2;
  localparam logic [1:0] PH_DROP = 2'd3;

  logic              item_v_r;
  in_item_t          item_r;
  logic              fire;

  logic [LEN_W-1:0]  max_transfer_r;
  logic [LEN_W-1:0]  reader_capacity_r;

  logic [1:0]        phase_r, phase_nxt;
  logic [BYTE_W-1:0] held_r, held_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  done_r, done_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic              inprog_r, inprog_nxt;

  logic [TIME_W-1:0] start_eff;
  logic [LEN_W-1:0]  len_hdr;
  logic              hdr_ok;
  logic [LEN_W-1:0]  done_inc;
  logic              done_end;

  // The held item moves on whenever the queue can take two results.
  assign fire     = item_v_r && space_ok;
  assign in_ready = !item_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_ready) begin
      item_v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_transfer_r    <= MAX_TRANSFER_RST;
      reader_capacity_r <= READER_CAPACITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_TRANSFER:    max_transfer_r    <= cfg_wdata;
        CFG_READER_CAPACITY: reader_capacity_r <= cfg_wdata;
        default:             ;
      endcase
    end
  end

  assign start_eff = inprog_r ? start_r : item_r.arrival_time_us;
  assign len_hdr   = {item_r.rx_byte[BYTE_W-2:0], held_r};
  assign hdr_ok    = (len_hdr >= MIN_LEN) && (len_hdr <= max_transfer_r);
  assign done_inc  = done_r + 1'b1;
  assign done_end  = done_inc >= len_r;

  always_comb begin
    phase_nxt   = phase_r;
    held_nxt    = held_r;
    len_nxt     = len_r;
    done_nxt    = done_r;
    start_nxt   = start_r;
    inprog_nxt  = inprog_r;
    push.count  = 2'd0;
    push.first  = '{out_byte: item_r.rx_byte, last_of_packet: 1'b0,
                    packet_time_us: start_eff, packet_length: len_r};
    push.second = '{out_byte: item_r.rx_byte, last_of_packet: 1'b0,
                    packet_time_us: start_eff, packet_length: len_hdr};
    if (fire) begin
      inprog_nxt = 1'b1;
      start_nxt  = start_eff;
      unique case (phase_r)
        PH_LOW: begin
          held_nxt  = item_r.rx_byte;
          phase_nxt = PH_HIGH;
        end
        PH_HIGH: begin
          if (!hdr_ok) begin
            // Resync: the second byte becomes the new first header byte.
            held_nxt   = item_r.rx_byte;
            inprog_nxt = 1'b0;
          end else begin
            len_nxt  = len_hdr;
            done_nxt = 15'd2;
            if (len_hdr > reader_capacity_r) begin
              phase_nxt = PH_DROP;
            end else begin
              phase_nxt  = PH_PASS;
              push.count = 2'd2;
              push.first = '{out_byte: held_r, last_of_packet: 1'b0,
                             packet_time_us: start_eff, packet_length: len_hdr};
            end
          end
        end
        PH_PASS: begin
          done_nxt                 = done_inc;
          push.count               = 2'd1;
          push.first.last_of_packet = done_end;
          if (done_end) begin
            phase_nxt  = PH_LOW;
            done_nxt   = '0;
            inprog_nxt = 1'b0;
          end
        end
        default: begin
          done_nxt = done_inc;
          if (done_end) begin
            phase_nxt  = PH_LOW;
            done_nxt   = '0;
            inprog_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LOW;
      held_r   <= '0;
      len_r    <= '0;
      done_r   <= '0;
      start_r  <= '0;
      inprog_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      held_r   <= held_nxt;
      len_r    <= len_nxt;
      done_r   <= done_nxt;
      start_r  <= start_nxt;
      inprog_r <= inprog_nxt;
    end
  end

endmodule

// ===== src/lppd_queue.sv =====
// Small result queue that takes up to two results per cycle and hands out one while out_ready is high.
module lppd_queue #(
  parameter int unsigned Depth = lppd_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lppd_pkg::push_t     push,
  output logic                space_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output lppd_pkg::out_item_t out_item
);
  import lppd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] RoomLimit = CntW'(Depth - 2);

  out_item_t       mem_r [Depth];
  logic [PtrW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PtrW-1:0] wp1, wp2;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            pop;

  assign wp1 = (wp_r == PtrLast) ? '0 : wp_r + 1'b1;
  assign wp2 = (wp1 == PtrLast) ? '0 : wp1 + 1'b1;

  assign out_valid = cnt_r != '0;
  assign out_item  = mem_r[rp_r];
  assign pop       = out_valid && out_ready;
  assign space_ok  = cnt_r <= RoomLimit;

  always_comb begin
    unique case (push.count)
      2'd1:    wp_nxt = wp1;
      2'd2:    wp_nxt = wp2;
      default: wp_nxt = wp_r;
    endcase
    rp_nxt  = pop ? ((rp_r == PtrLast) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + CntW'(push.count) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push.count != 2'd0) begin
      mem_r[wp_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem_r[wp1] <= push.second;
    end
  end

endmodule
